// ===== rtl/assert_macros.svh =====
// assertion macros shared by the bit packer rtl
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/lbp_pkg.sv =====
// shared types and constants of the lsb-first bit packer
// no dependencies; imported by every rtl module
package lbp_pkg;

    localparam int MAX_FIELD_BITS = 32;
    localparam int FM_W           = MAX_FIELD_BITS + 1;
    localparam int OP_W           = 2;
    localparam int VALUE_W        = 32;
    localparam int SIZE_W         = 6;
    localparam int OFFSET_W       = 14;
    localparam int RIDX_W         = 10;
    localparam int POS_W          = 14;
    localparam int EXT_W          = POS_W + 1;
    localparam int BYTES_W        = 11;
    localparam int CFG_W          = 11;
    localparam int BYTE_W         = 8;
    // a field plus up to seven bits of lead-in touches this many bytes
    localparam int SPAN_BYTES     = (MAX_FIELD_BITS + 14) / 8;
    localparam int SPAN_W         = SPAN_BYTES * BYTE_W;
    localparam int CNT_W          = $clog2(SPAN_BYTES + 1);
    localparam int JOB_AW         = BYTES_W + 1;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_PATCH  = 2'd1,
        OP_ALIGN  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef struct packed {
        logic load;
        logic prep;
        logic clr;
        logic rd;
        logic mrg;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic has_work;
        logic is_read;
        logic cnt_last;
    } t_dp_stat;

endpackage

// ===== rtl/lsb_first_bit_packer_top.sv =====
// lsb-first bit packer top level; uses lbp_pkg, lbp_ctrl, lbp_datapath, assert_macros.svh
// from accept to the o_valid strobe: prep and finish with no store access, plus a store
//   read for read byte, plus a read and one memory read-modify-write per byte for a write
//   that touches 1 to 5 bytes; a new transaction is taken in the strobe cycle
// synchronous active-low reset; afterwards busy stays high while the
//   byte store is swept to zero; the receiver cannot stall the result
`include "assert_macros.svh"

module lsb_first_bit_packer_top #(
    parameter int BUF_BYTES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [lbp_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic [lbp_pkg::OP_W-1:0]      i_op,
    input  logic [lbp_pkg::VALUE_W-1:0]   i_value,
    input  logic [lbp_pkg::SIZE_W-1:0]    i_field_len,
    input  logic [lbp_pkg::OFFSET_W-1:0]  i_patch_pos,
    input  logic [lbp_pkg::RIDX_W-1:0]    i_read_index,
    output logic                          o_valid,
    output logic                          o_status,
    output logic [lbp_pkg::POS_W-1:0]     o_bit_position,
    output logic [lbp_pkg::BYTES_W-1:0]   o_bytes_written,
    output logic [lbp_pkg::BYTE_W-1:0]    o_read_data
);
    import lbp_pkg::*;

    // command and status between controller and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // controller: clear sweep, then prep / read / merge loop / finish per transaction
    lbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // datapath: byte store, append position, field shifter and result registers
    lbp_datapath #(
        .BUF_BYTES (BUF_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (i_op),
        .i_value       (i_value),
        .i_field_len   (i_field_len),
        .i_patch_pos   (i_patch_pos),
        .i_read_index  (i_read_index),
        .o_res_status  (o_status),
        .o_res_pos     (o_bit_position),
        .o_res_bytes   (o_bytes_written),
        .o_res_rdata   (o_read_data)
    );

    // an accepted transaction keeps the block busy on the following cycle
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // a result strobe follows a busy cycle
    `ASSERT_IMPLY(a_valid_after_busy, i_clk, i_rst_n, o_valid, $past(busy))
    // one strobe per transaction, never two in a row
    `ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    // overflow only comes from append or patch, which return no read data
    `ASSERT_IMPLY(a_ovf_no_rdata, i_clk, i_rst_n, o_valid && o_status, o_read_data == '0)

endmodule

// ===== rtl/lbp_datapath.sv =====
// datapath of the bit packer: byte memory, position, field shifter, result registers
// depends on lbp_pkg
module lbp_datapath #(
    parameter int BUF_BYTES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lbp_pkg::t_dp_cmd           i_cmd,
    output lbp_pkg::t_dp_stat          o_stat,
    input  logic                       i_cfg_we,
    input  logic [lbp_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic [lbp_pkg::OP_W-1:0]   i_op,
    input  logic [lbp_pkg::VALUE_W-1:0] i_value,
    input  logic [lbp_pkg::SIZE_W-1:0] i_field_len,
    input  logic [lbp_pkg::OFFSET_W-1:0] i_patch_pos,
    input  logic [lbp_pkg::RIDX_W-1:0] i_read_index,
    output logic                       o_res_status,
    output logic [lbp_pkg::POS_W-1:0]  o_res_pos,
    output logic [lbp_pkg::BYTES_W-1:0] o_res_bytes,
    output logic [lbp_pkg::BYTE_W-1:0] o_res_rdata
);
    import lbp_pkg::*;

    localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUF_BYTES - 1);

    logic [BYTE_W-1:0] mem [BUF_BYTES];

    logic [CFG_W-1:0]    r_cfg;
    logic [POS_W-1:0]    r_pos;
    logic [AW-1:0]       r_clr_addr;
    t_op                 r_op;
    logic [VALUE_W-1:0]  r_value;
    logic [SIZE_W-1:0]   r_size;
    logic [OFFSET_W-1:0] r_offset;
    logic [RIDX_W-1:0]   r_ridx;
    logic                r_status;
    logic [SPAN_W-1:0]   r_data;
    logic [SPAN_W-1:0]   r_mask;
    logic [JOB_AW-1:0]   r_addr;
    logic [CNT_W-1:0]    r_cnt;
    logic [BYTE_W-1:0]   r_mem_q;
    logic                r_res_status;
    logic [POS_W-1:0]    r_res_pos;
    logic [BYTES_W-1:0]  r_res_bytes;
    logic [BYTE_W-1:0]   r_res_rdata;

    logic [31:0]         usable_bytes;
    logic [EXT_W-1:0]    limit_bits;
    logic [POS_W-1:0]    start_bit;
    logic [EXT_W-1:0]    end_bit;
    logic                over;
    logic [2:0]          sh;
    logic                size_nz;
    logic                ovf;
    logic                wr;
    logic [SIZE_W-1:0]   job_size;
    logic [FM_W-1:0]     one_sh;
    logic [FM_W-1:0]     fm_full;
    logic [MAX_FIELD_BITS-1:0] fmask;
    logic [VALUE_W-1:0]  job_val;
    logic [SIZE_W:0]     span_sum;
    logic [POS_W-1:0]    n_pos;
    logic                addr_ok;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [BYTE_W-1:0]   mem_wd;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;

    // usable length saturated to the store size
    assign usable_bytes = (32'(r_cfg) > 32'(BUF_BYTES)) ? 32'(BUF_BYTES) : 32'(r_cfg);
    assign limit_bits   = EXT_W'(usable_bytes << 3);
    assign start_bit    = (r_op == OP_PATCH) ? r_offset : r_pos;
    assign end_bit      = EXT_W'(start_bit) + EXT_W'(r_size);
    assign over         = end_bit > limit_bits;
    assign sh           = start_bit[2:0];
    assign size_nz      = r_size != '0;

    always_comb begin
        ovf = 1'b0;
        wr  = 1'b0;
        case (r_op)
            OP_APPEND: begin
                ovf = size_nz && over;
                wr  = size_nz && !over;
            end
            OP_PATCH: begin
                ovf = over;
                wr  = size_nz && !over;
            end
            OP_ALIGN: begin
                wr  = sh != 3'd0;
            end
            default: begin
                ovf = 1'b0;
            end
        endcase
    end

    // align is a write of zero bits up to the byte boundary
    assign job_size = (r_op == OP_ALIGN) ? (SIZE_W'(8) - SIZE_W'(sh)) : r_size;
    assign one_sh   = FM_W'(1) << job_size;
    assign fm_full  = one_sh - FM_W'(1);
    assign fmask    = fm_full[MAX_FIELD_BITS-1:0];
    assign job_val  = (r_op == OP_ALIGN) ? '0 : (r_value & fmask);
    assign span_sum = (SIZE_W+1)'(sh) + (SIZE_W+1)'(job_size) + (SIZE_W+1)'(7);

    always_comb begin
        n_pos = r_pos;
        if (wr && r_op == OP_APPEND) begin
            n_pos = r_pos + POS_W'(r_size);
        end else if (wr && r_op == OP_ALIGN) begin
            n_pos = {r_pos[POS_W-1:3] + (POS_W-3)'(1), 3'b000};
        end
    end

    assign addr_ok = 32'(r_addr) < 32'(BUF_BYTES);

    // one write port, one registered read port
    assign mem_we = i_cmd.clr || (i_cmd.mrg && addr_ok);
    assign mem_wa = i_cmd.clr ? r_clr_addr : AW'(r_addr);
    assign mem_wd = i_cmd.clr ? '0
                  : ((r_mem_q & ~r_mask[BYTE_W-1:0]) | (r_data[BYTE_W-1:0] & r_mask[BYTE_W-1:0]));
    assign mem_re = i_cmd.rd || i_cmd.mrg;
    assign mem_ra = i_cmd.mrg ? AW'(r_addr + JOB_AW'(1)) : AW'(r_addr);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= CFG_RESET;
            r_pos      <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.prep) begin
                r_pos <= n_pos;
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_op);
            r_value  <= i_value;
            r_size   <= (i_field_len > SIZE_W'(MAX_FIELD_BITS)) ? SIZE_W'(MAX_FIELD_BITS)
                                                               : i_field_len;
            r_offset <= i_patch_pos;
            r_ridx   <= i_read_index;
        end
        if (i_cmd.prep) begin
            r_status <= ovf;
            r_data   <= SPAN_W'(job_val) << sh;
            r_mask   <= SPAN_W'(fmask) << sh;
            r_cnt    <= wr ? CNT_W'(span_sum >> 3) : '0;
            r_addr   <= (r_op == OP_READ) ? JOB_AW'(r_ridx) : JOB_AW'(start_bit >> 3);
        end
        if (i_cmd.mrg) begin
            r_data <= r_data >> BYTE_W;
            r_mask <= r_mask >> BYTE_W;
            r_addr <= r_addr + JOB_AW'(1);
            r_cnt  <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.fin) begin
            r_res_status <= r_status;
            r_res_pos    <= r_pos;
            r_res_bytes  <= BYTES_W'((EXT_W'(r_pos) + EXT_W'(7)) >> 3);
            r_res_rdata  <= (r_op == OP_READ && addr_ok) ? r_mem_q : '0;
        end
    end

    assign o_stat.clr_last = r_clr_addr == LAST_ADDR;
    assign o_stat.has_work = wr || (r_op == OP_READ);
    assign o_stat.is_read  = r_op == OP_READ;
    assign o_stat.cnt_last = r_cnt == CNT_W'(1);

    assign o_res_status = r_res_status;
    assign o_res_pos    = r_res_pos;
    assign o_res_bytes  = r_res_bytes;
    assign o_res_rdata  = r_res_rdata;

endmodule

// ===== rtl/lbp_ctrl.sv =====
// controller state machine of the bit packer
// depends on lbp_pkg; drives lbp_datapath through command and status structs
module lbp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_valid,
    output lbp_pkg::t_dp_cmd  o_cmd,
    input  lbp_pkg::t_dp_stat i_stat
);
    import lbp_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_RD,
        S_MRG,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_start) n_state = S_PREP;
            S_PREP:  n_state = i_stat.has_work ? S_RD : S_FIN;
            S_RD:    n_state = i_stat.is_read ? S_FIN : S_MRG;
            S_MRG:   if (i_stat.cnt_last) n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.load = (r_state == S_IDLE) && i_start;
    assign o_cmd.prep = r_state == S_PREP;
    assign o_cmd.clr  = r_state == S_CLEAR;
    assign o_cmd.rd   = r_state == S_RD;
    assign o_cmd.mrg  = r_state == S_MRG;
    assign o_cmd.fin  = r_state == S_FIN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_state != S_IDLE;
            r_valid <= r_state == S_FIN;
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

endmodule
